@@ rtl/oaat_pkg.sv @@
// Shared types, codes and constants of the open addressing attribute table.
package oaat_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int SMALL_LIMIT_DEF = 8;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 64;

  localparam int CMD_W     = 2;
  localparam int KEY_FW    = 32;
  localparam int HASH_W    = 32;
  localparam int VALUE_FW  = 64;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 7;
  localparam int LEN_CFG_W = 7;

  localparam logic [LEN_CFG_W-1:0] LEN_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIND   = 2'd0,
    CMD_PUT    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MARK_FREE = 2'd0,
    MARK_LIVE = 2'd1,
    MARK_TOMB = 2'd2
  } mark_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_INSERTED = 3'd1,
    ST_MISS     = 3'd2,
    ST_FULL     = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [KEY_FW-1:0]   key;
    logic [HASH_W-1:0]   key_hash;
    logic [VALUE_FW-1:0] value;
  } in_req_t;

  typedef struct packed {
    status_t              status;
    logic [VALUE_FW-1:0]  found_value;
    logic [COUNT_W-1:0]   entries_held;
  } out_rsp_t;

endpackage

@@ rtl/oaat_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module oaat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/oaat_mod.sv @@
// Bit-serial remainder of the key hash by the table length.
module oaat_mod #(
  parameter int LEN_W = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [oaat_pkg::HASH_W-1:0] dividend,
  input  logic [LEN_W-1:0]           divisor,
  output logic                       done,
  output logic [LEN_W-1:0]           remainder
);

  localparam int BC_W = $clog2(oaat_pkg::HASH_W);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [BC_W-1:0]             bit_cnt_r, bit_cnt_nxt;
  logic [oaat_pkg::HASH_W-1:0] shift_r, shift_nxt;
  logic [LEN_W-1:0]            rem_r, rem_nxt;
  logic [LEN_W-1:0]            div_r, div_nxt;
  logic [LEN_W:0]              trial;
  logic [LEN_W:0]              rem_step;

  // one restoring step: bring in the next hash bit, subtract if it fits
  assign trial    = {rem_r, shift_r[oaat_pkg::HASH_W-1]};
  assign rem_step = (trial >= {1'b0, div_r}) ? (trial - {1'b0, div_r}) : trial;

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    rem_nxt     = rem_r;
    div_nxt     = div_r;
    if (start) begin
      busy_nxt    = 1'b1;
      bit_cnt_nxt = '0;
      shift_nxt   = dividend;
      rem_nxt     = '0;
      div_nxt     = divisor;
    end else if (busy_r) begin
      rem_nxt     = rem_step[LEN_W-1:0];
      shift_nxt   = {shift_r[oaat_pkg::HASH_W-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r + BC_W'(1);
      if (bit_cnt_r == BC_W'(oaat_pkg::HASH_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bit_cnt_r <= bit_cnt_nxt;
    shift_r   <= shift_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

@@ rtl/open_addressing_attribute_table.sv @@
// Top level of the open addressing attribute table (find, put, remove by key).
// A request of length at most SMALL_LIMIT is served by a linear scan from slot zero;
//   above that, a serial remainder of the key hash by the length gives the start slot.
// Throughput: one request at a time, and the probe reads one slot per cycle;
//   an invalid request skips the probe and goes straight to the result.
// Reset: synchronous, active low; a clearing pass marks all CAPACITY slots free,
//   one per cycle, before the first request is taken.
module open_addressing_attribute_table #(
  parameter int CAPACITY    = oaat_pkg::CAPACITY_DEF,
  parameter int SMALL_LIMIT = oaat_pkg::SMALL_LIMIT_DEF,
  parameter int KEY_WIDTH   = oaat_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = oaat_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  oaat_pkg::in_req_t              in_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output oaat_pkg::out_rsp_t             out_rsp,
  input  logic                           cfg_we,
  input  logic [oaat_pkg::LEN_CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int SKW    = (KEY_WIDTH < oaat_pkg::KEY_FW) ? KEY_WIDTH : oaat_pkg::KEY_FW;
  localparam int WORD_W = 2 + SKW + VALUE_WIDTH;
  localparam int LCW    = (LEN_W > oaat_pkg::LEN_CFG_W) ? LEN_W : oaat_pkg::LEN_CFG_W;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  oaat_pkg::state_t               state_r, state_nxt;
  logic [oaat_pkg::LEN_CFG_W-1:0] len_cfg_r;
  logic [IDX_W-1:0]               clr_idx_r, clr_idx_nxt;
  logic [oaat_pkg::CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [SKW-1:0]                 key_r, key_nxt;
  logic [VALUE_WIDTH-1:0]         val_in_r, val_in_nxt;
  logic                           inv_r, inv_nxt;
  logic                           hash_mode_r, hash_mode_nxt;
  logic [IDX_W-1:0]               iss_idx_r, iss_idx_nxt;
  logic [LEN_W-1:0]               iss_cnt_r, iss_cnt_nxt;
  logic                           chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]               chk_idx_r, chk_idx_nxt;
  logic                           chk_last_r, chk_last_nxt;
  logic                           hit_r, hit_nxt;
  logic [IDX_W-1:0]               pos_r, pos_nxt;
  logic                           ins_v_r, ins_v_nxt;
  logic [IDX_W-1:0]               ins_r, ins_nxt;
  logic [VALUE_WIDTH-1:0]         fval_r, fval_nxt;
  logic [oaat_pkg::COUNT_W-1:0]   live_r, live_nxt;
  logic                           out_valid_r, out_valid_nxt;
  oaat_pkg::out_rsp_t             out_rsp_r, out_rsp_nxt;

  // ---------------------------------------------------------------------------
  // Effective length: zero acts as one, anything above CAPACITY as CAPACITY
  // ---------------------------------------------------------------------------
  logic [LCW-1:0]   len_ext;
  logic [LEN_W-1:0] eff_len;
  logic [IDX_W-1:0] last_idx;
  logic             in_big;

  assign len_ext = LCW'(len_cfg_r);

  always_comb begin
    if (len_ext == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_ext > LCW'(CAPACITY)) begin
      eff_len = LEN_W'(CAPACITY);
    end else begin
      eff_len = len_ext[LEN_W-1:0];
    end
  end

  assign last_idx = IDX_W'(eff_len - LEN_W'(1));
  // above the small limit the probe starts at hash mod length
  assign in_big   = {{(32 - LEN_W){1'b0}}, eff_len} > 32'(SMALL_LIMIT);

  // ---------------------------------------------------------------------------
  // Input decode: mask the key to its stored width, reject key zero and the
  // unused command code
  // ---------------------------------------------------------------------------
  logic [SKW-1:0]         in_key;
  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_cmd_ok;
  logic                   in_invalid;
  logic                   in_take;
  logic                   out_free;

  assign in_key     = in_req.key[SKW-1:0];
  assign in_val     = in_req.value[VALUE_WIDTH-1:0];
  assign in_cmd_ok  = (in_req.command == oaat_pkg::CMD_FIND) ||
                      (in_req.command == oaat_pkg::CMD_PUT) ||
                      (in_req.command == oaat_pkg::CMD_REMOVE);
  assign in_invalid = (in_key == '0) || !in_cmd_ok;
  assign in_take    = in_valid && !in_stall;
  // the output register can load when empty or when its request leaves now
  assign out_free   = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------------
  // Slot RAM: {mark, key, value} per slot
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  oaat_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [1:0]             rd_mark;
  logic [SKW-1:0]         rd_key;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic                   rd_live;
  logic                   rd_match;
  logic                   stop_now;

  assign rd_mark  = ram_rdata[WORD_W-1 -: 2];
  assign rd_key   = ram_rdata[VALUE_WIDTH +: SKW];
  assign rd_value = ram_rdata[VALUE_WIDTH-1:0];
  assign rd_live  = (rd_mark == oaat_pkg::MARK_LIVE);
  assign rd_match = rd_live && (rd_key == key_r);

  // Stop on a key match, on a never-used slot when hashing, or after the
  // last slot of the length has been checked.
  assign stop_now = chk_v_r &&
                    (rd_match ||
                     (hash_mode_r && (rd_mark == oaat_pkg::MARK_FREE)) ||
                     chk_last_r);

  // ---------------------------------------------------------------------------
  // Hash remainder unit
  // ---------------------------------------------------------------------------
  logic             mod_start;
  logic             mod_done;
  logic [LEN_W-1:0] mod_rem;

  oaat_mod #(
    .LEN_W (LEN_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_req.key_hash),
    .divisor   (eff_len),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // ---------------------------------------------------------------------------
  // Finish decision: status, found value, new count and the one write back
  // ---------------------------------------------------------------------------
  oaat_pkg::status_t            fin_status;
  logic [VALUE_WIDTH-1:0]       fin_fv;
  logic [oaat_pkg::COUNT_W-1:0] fin_live;
  logic                         fin_wr;
  logic [IDX_W-1:0]             fin_addr;
  oaat_pkg::mark_t              fin_mark;
  logic                         fin_keep_val;

  always_comb begin
    fin_status   = oaat_pkg::ST_INVALID;
    fin_fv       = '0;
    fin_live     = live_r;
    fin_wr       = 1'b0;
    fin_addr     = pos_r;
    fin_mark     = oaat_pkg::MARK_LIVE;
    fin_keep_val = 1'b1;
    if (!inv_r) begin
      case (cmd_r)
        oaat_pkg::CMD_FIND: begin
          if (hit_r) begin
            fin_status = oaat_pkg::ST_HIT;
            fin_fv     = fval_r;
          end else begin
            fin_status = oaat_pkg::ST_MISS;
          end
        end
        oaat_pkg::CMD_PUT: begin
          if (hit_r) begin
            // update in place
            fin_status = oaat_pkg::ST_HIT;
            fin_wr     = 1'b1;
          end else if (ins_v_r) begin
            // fill the first tombstone or free slot met on the way
            fin_status = oaat_pkg::ST_INSERTED;
            fin_wr     = 1'b1;
            fin_addr   = ins_r;
            fin_live   = live_r + oaat_pkg::COUNT_W'(1);
          end else begin
            fin_status = oaat_pkg::ST_FULL;
          end
        end
        oaat_pkg::CMD_REMOVE: begin
          if (hit_r) begin
            // leave a tombstone so later probes keep going past it
            fin_status   = oaat_pkg::ST_HIT;
            fin_wr       = 1'b1;
            fin_mark     = oaat_pkg::MARK_TOMB;
            fin_keep_val = 1'b0;
            if (live_r != '0) begin
              fin_live = live_r - oaat_pkg::COUNT_W'(1);
            end
          end else begin
            fin_status = oaat_pkg::ST_MISS;
          end
        end
        default: begin
          fin_status = oaat_pkg::ST_INVALID;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oaat_pkg::S_CLEAR: begin
        if (clr_idx_r == IDX_W'(CAPACITY - 1)) begin
          state_nxt = oaat_pkg::S_IDLE;
        end
      end
      oaat_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_invalid) begin
            state_nxt = oaat_pkg::S_FINISH;
          end else if (in_big) begin
            state_nxt = oaat_pkg::S_MOD;
          end else begin
            state_nxt = oaat_pkg::S_PROBE;
          end
        end
      end
      oaat_pkg::S_MOD: begin
        if (mod_done) begin
          state_nxt = oaat_pkg::S_PROBE;
        end
      end
      oaat_pkg::S_PROBE: begin
        if (stop_now) begin
          state_nxt = oaat_pkg::S_FINISH;
        end
      end
      oaat_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt = oaat_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = oaat_pkg::S_CLEAR;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs (handshake, RAM port controls, remainder start)
  // ---------------------------------------------------------------------------
  logic issue;

  always_comb begin
    in_stall  = 1'b1;
    mod_start = 1'b0;
    issue     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = fin_addr;
    ram_wdata = {fin_mark, key_r, (fin_keep_val ? val_in_r : {VALUE_WIDTH{1'b0}})};
    case (state_r)
      oaat_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = {oaat_pkg::MARK_FREE, {(SKW + VALUE_WIDTH){1'b0}}};
      end
      oaat_pkg::S_IDLE: begin
        in_stall  = 1'b0;
        mod_start = in_valid && !in_invalid && in_big;
      end
      oaat_pkg::S_PROBE: begin
        // read one slot per cycle ahead of the check; stop issuing once done
        issue = (iss_cnt_r < eff_len) && !stop_now;
      end
      oaat_pkg::S_FINISH: begin
        // the write back lands before the next request can read
        ram_we = fin_wr && out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign ram_re    = issue;
  assign ram_raddr = iss_idx_r;

  // ---------------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------------
  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_in_nxt    = val_in_r;
    inv_nxt       = inv_r;
    hash_mode_nxt = hash_mode_r;
    iss_idx_nxt   = iss_idx_r;
    iss_cnt_nxt   = iss_cnt_r;
    chk_v_nxt     = 1'b0;
    chk_idx_nxt   = iss_idx_r;
    chk_last_nxt  = (iss_cnt_r == (eff_len - LEN_W'(1)));
    hit_nxt       = hit_r;
    pos_nxt       = pos_r;
    ins_v_nxt     = ins_v_r;
    ins_nxt       = ins_r;
    fval_nxt      = fval_r;
    live_nxt      = live_r;
    // drop the held result once it is taken
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;

    if (state_r == oaat_pkg::S_CLEAR) begin
      clr_idx_nxt = clr_idx_r + IDX_W'(1);
    end

    // capture the request
    if (in_take) begin
      cmd_nxt       = in_req.command;
      key_nxt       = in_key;
      val_in_nxt    = in_val;
      inv_nxt       = in_invalid;
      hash_mode_nxt = in_big;
      iss_idx_nxt   = '0;
      iss_cnt_nxt   = '0;
      hit_nxt       = 1'b0;
      ins_v_nxt     = 1'b0;
    end

    // hashed start position
    if ((state_r == oaat_pkg::S_MOD) && mod_done) begin
      iss_idx_nxt = mod_rem[IDX_W-1:0];
    end

    // advance the read pointer, wrapping at the length
    if (issue) begin
      chk_v_nxt   = 1'b1;
      iss_cnt_nxt = iss_cnt_r + LEN_W'(1);
      iss_idx_nxt = (iss_idx_r == last_idx) ? '0 : (iss_idx_r + IDX_W'(1));
    end

    // check the slot read in the previous cycle
    if (chk_v_r) begin
      if (rd_match) begin
        hit_nxt  = 1'b1;
        pos_nxt  = chk_idx_r;
        fval_nxt = rd_value;
      end else if (!rd_live && !ins_v_r) begin
        ins_v_nxt = 1'b1;
        ins_nxt   = chk_idx_r;
      end
    end

    // hand the result over and commit the count
    if ((state_r == oaat_pkg::S_FINISH) && out_free) begin
      live_nxt                 = fin_live;
      out_valid_nxt            = 1'b1;
      out_rsp_nxt.status       = fin_status;
      out_rsp_nxt.found_value  = oaat_pkg::VALUE_FW'(fin_fv);
      out_rsp_nxt.entries_held = fin_live;
    end
  end

  // ---------------------------------------------------------------------------
  // Register update
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oaat_pkg::S_CLEAR;
      clr_idx_r   <= '0;
      len_cfg_r   <= oaat_pkg::LEN_RESET;
      chk_v_r     <= 1'b0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      chk_v_r     <= chk_v_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        len_cfg_r <= cfg_wdata;
      end
    end
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    val_in_r    <= val_in_nxt;
    inv_r       <= inv_nxt;
    hash_mode_r <= hash_mode_nxt;
    iss_idx_r   <= iss_idx_nxt;
    iss_cnt_r   <= iss_cnt_nxt;
    chk_idx_r   <= chk_idx_nxt;
    chk_last_r  <= chk_last_nxt;
    hit_r       <= hit_nxt;
    pos_r       <= pos_nxt;
    ins_v_r     <= ins_v_nxt;
    ins_r       <= ins_nxt;
    fval_r      <= fval_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == oaat_pkg::S_FINISH) && ram_we) |-> (ram_waddr < eff_len))
    else $error("write back outside the table length");

  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == oaat_pkg::S_MOD))
    else $error("remainder finished outside the remainder state");

  a_chk_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
    chk_v_r |-> (state_r == oaat_pkg::S_PROBE))
    else $error("slot read data pending outside the probe");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == oaat_pkg::S_FINISH))
    else $error("result loaded outside the finish state");

endmodule
